FILE: rtl/core/tmp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the trapezoidal motion profile core.
// No dependencies; used by tmp_setup and trapezoidal_motion_profile_core.

package tmp_pkg;

    localparam int REG_BITS   = 31;
    localparam int IDX_BITS   = 3;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int CNT_BITS   = 6;

    typedef enum logic [2:0] {
        CFG_START_VEL  = 3'd0,
        CFG_CRUISE_VEL = 3'd1,
        CFG_ACCEL      = 3'd2,
        CFG_END_VEL    = 3'd3,
        CFG_DISTANCE   = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [4:0] {
        ST_START, ST_SQ_VI, ST_SQ_VF, ST_SQ_VC, ST_AD, ST_HALF, ST_DIST_I, ST_DIST_F,
        ST_TRI_CHK, ST_SQRT, ST_SQ_PK, ST_DA, ST_DD, ST_TA, ST_TD, ST_DADD, ST_DC,
        ST_TC, ST_SUM1, ST_SUM2, ST_DONE
    } setup_state_t;

    // Profile constants handed from the setup sequencer to the query pipeline.
    typedef struct packed {
        logic                busy;
        logic                err;
        logic [REG_BITS-1:0] peak;
        logic [REG_BITS-1:0] vend;
        logic [63:0]         da;
        logic [63:0]         dadc;
        logic [63:0]         dsum;
        logic [63:0]         ta;
        logic [63:0]         t1;
        logic [63:0]         t2;
    } prof_t;

endpackage

FILE: rtl/core/tmp_setup.sv
`timescale 1ns / 1ps
// Setup sequencer: derives peak velocity, phase distances and phase times.
// Depends on tmp_pkg; one shared multiplier, a 64-step divider and a square root.

module tmp_setup #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tmp_pkg::REG_BITS-1:0] vi,
    input  logic [tmp_pkg::REG_BITS-1:0] vc,
    input  logic [tmp_pkg::REG_BITS-1:0] acc,
    input  logic [tmp_pkg::REG_BITS-1:0] vf,
    input  logic [tmp_pkg::REG_BITS-1:0] travel,
    output tmp_pkg::prof_t               prof
);

    tmp_pkg::setup_state_t state_reg, state_next;

    logic [63:0] sq_vi_reg, sq_vf_reg, sq_vc_reg, sq_pk_reg, ad_reg, half_reg, rad_reg;
    logic [63:0] dist_i_reg, dist_f_reg, da_reg, dd_reg, ta_reg, td_reg, tc_reg;
    logic [63:0] dadd_reg, dc_reg, dadc_reg, dsum_reg, t1_reg, t2_reg;
    logic [tmp_pkg::REG_BITS-1:0] peak_reg, vend_reg;
    logic err_reg;

    logic [63:0] quo_reg, sx_reg, sr_reg, bit_reg;
    logic [31:0] rem_reg, den_reg;
    logic act_reg;
    logic [tmp_pkg::CNT_BITS-1:0] cnt_reg;

    logic [tmp_pkg::REG_BITS-1:0] mul_x, mul_y;
    logic [61:0] prod;
    logic [63:0] div_num;
    logic [31:0] div_den;
    logic is_div, is_sqrt, unit_run, done_step, tri_case;
    logic [tmp_pkg::CNT_BITS-1:0] last_cnt;
    logic [32:0] rs;
    logic dge, sge;
    logic [31:0] rem_step;
    logic [63:0] quo_step, rb, sx_step, sr_step, d64;
    logic [tmp_pkg::REG_BITS-1:0] diff_i, diff_f;

    assign d64    = {33'b0, travel};
    assign diff_i = peak_reg - vi;
    assign diff_f = peak_reg - vf;
    assign prod   = mul_x * mul_y;

    // Operand selection for the shared multiplier and divider.
    always_comb
    begin
        mul_x   = '0;
        mul_y   = '0;
        div_num = '0;
        div_den = {acc, 1'b0};
        is_div  = 1'b0;
        is_sqrt = 1'b0;
        unique case (state_reg)
            tmp_pkg::ST_SQ_VI: begin mul_x = vi; mul_y = vi; end
            tmp_pkg::ST_SQ_VF: begin mul_x = vf; mul_y = vf; end
            tmp_pkg::ST_SQ_VC: begin mul_x = vc; mul_y = vc; end
            tmp_pkg::ST_AD:    begin mul_x = acc; mul_y = travel; end
            tmp_pkg::ST_SQ_PK: begin mul_x = peak_reg; mul_y = peak_reg; end
            tmp_pkg::ST_DIST_I:
            begin
                is_div  = 1'b1;
                div_num = (vc > vi) ? sq_vc_reg - sq_vi_reg : '0;
            end
            tmp_pkg::ST_DIST_F:
            begin
                is_div  = 1'b1;
                div_num = (vc > vf) ? sq_vc_reg - sq_vf_reg : '0;
            end
            tmp_pkg::ST_DA:
            begin
                is_div  = 1'b1;
                div_num = (peak_reg > vi) ? sq_pk_reg - sq_vi_reg : '0;
            end
            tmp_pkg::ST_DD:
            begin
                is_div  = 1'b1;
                div_num = (peak_reg > vf) ? sq_pk_reg - sq_vf_reg : '0;
            end
            tmp_pkg::ST_TA:
            begin
                is_div  = 1'b1;
                div_num = (peak_reg > vi) ? ({33'b0, diff_i} << FRAC_BITS) : '0;
                div_den = {1'b0, acc};
            end
            tmp_pkg::ST_TD:
            begin
                is_div  = 1'b1;
                div_num = (peak_reg > vf) ? ({33'b0, diff_f} << FRAC_BITS) : '0;
                div_den = {1'b0, acc};
            end
            tmp_pkg::ST_TC:
            begin
                is_div  = 1'b1;
                div_num = dc_reg << FRAC_BITS;
                div_den = {1'b0, peak_reg};
            end
            tmp_pkg::ST_SQRT: is_sqrt = 1'b1;
            default: ;
        endcase
    end

    assign unit_run  = is_div || is_sqrt;
    assign last_cnt  = is_sqrt ? tmp_pkg::CNT_BITS'(tmp_pkg::SQRT_STEPS - 1)
                               : tmp_pkg::CNT_BITS'(tmp_pkg::DIV_STEPS - 1);
    assign done_step = act_reg && (cnt_reg == last_cnt);

    // One restoring division step and one square-root digit step.
    assign rs       = {rem_reg, quo_reg[63]};
    assign dge      = rs >= {1'b0, den_reg};
    assign rem_step = dge ? 32'(rs - {1'b0, den_reg}) : rs[31:0];
    assign quo_step = {quo_reg[62:0], dge};
    assign rb       = sr_reg + bit_reg;
    assign sge      = sx_reg >= rb;
    assign sx_step  = sge ? sx_reg - rb : sx_reg;
    assign sr_step  = sge ? (sr_reg >> 1) + bit_reg : sr_reg >> 1;

    assign tri_case = (dist_i_reg + dist_f_reg) > d64;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tmp_pkg::ST_START:
                state_next = (acc == '0) ? tmp_pkg::ST_DONE : tmp_pkg::ST_SQ_VI;
            tmp_pkg::ST_SQ_VI:   state_next = tmp_pkg::ST_SQ_VF;
            tmp_pkg::ST_SQ_VF:   state_next = tmp_pkg::ST_SQ_VC;
            tmp_pkg::ST_SQ_VC:   state_next = tmp_pkg::ST_AD;
            tmp_pkg::ST_AD:      state_next = tmp_pkg::ST_HALF;
            tmp_pkg::ST_HALF:    state_next = tmp_pkg::ST_DIST_I;
            tmp_pkg::ST_DIST_I:  if (done_step) state_next = tmp_pkg::ST_DIST_F;
            tmp_pkg::ST_DIST_F:  if (done_step) state_next = tmp_pkg::ST_TRI_CHK;
            tmp_pkg::ST_TRI_CHK:
                state_next = tri_case ? tmp_pkg::ST_SQRT : tmp_pkg::ST_SQ_PK;
            tmp_pkg::ST_SQRT:    if (done_step) state_next = tmp_pkg::ST_SQ_PK;
            tmp_pkg::ST_SQ_PK:   state_next = tmp_pkg::ST_DA;
            tmp_pkg::ST_DA:      if (done_step) state_next = tmp_pkg::ST_DD;
            tmp_pkg::ST_DD:      if (done_step) state_next = tmp_pkg::ST_TA;
            tmp_pkg::ST_TA:      if (done_step) state_next = tmp_pkg::ST_TD;
            tmp_pkg::ST_TD:      if (done_step) state_next = tmp_pkg::ST_DADD;
            tmp_pkg::ST_DADD:    state_next = tmp_pkg::ST_DC;
            tmp_pkg::ST_DC:      state_next = tmp_pkg::ST_TC;
            tmp_pkg::ST_TC:      if (done_step) state_next = tmp_pkg::ST_SUM1;
            tmp_pkg::ST_SUM1:    state_next = tmp_pkg::ST_SUM2;
            tmp_pkg::ST_SUM2:    state_next = tmp_pkg::ST_DONE;
            tmp_pkg::ST_DONE:    state_next = tmp_pkg::ST_DONE;
            default:             state_next = tmp_pkg::ST_START;
        endcase
        if (start)
        begin
            state_next = tmp_pkg::ST_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmp_pkg::ST_START;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            act_reg <= 1'b0;
        end
        else if (unit_run)
        begin
            if (!act_reg)
            begin
                act_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (done_step)
            begin
                act_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (unit_run)
        begin
            if (!act_reg)
            begin
                quo_reg <= div_num;
                rem_reg <= '0;
                den_reg <= div_den;
                sx_reg  <= rad_reg;
                sr_reg  <= '0;
                bit_reg <= 64'd1 << 62;
            end
            else
            begin
                quo_reg <= quo_step;
                rem_reg <= rem_step;
                sx_reg  <= sx_step;
                sr_reg  <= sr_step;
                bit_reg <= bit_reg >> 2;
            end
        end

        unique case (state_reg)
            tmp_pkg::ST_START:  err_reg   <= (acc == '0);
            tmp_pkg::ST_SQ_VI:  sq_vi_reg <= {2'b0, prod};
            tmp_pkg::ST_SQ_VF:  sq_vf_reg <= {2'b0, prod};
            tmp_pkg::ST_SQ_VC:  sq_vc_reg <= {2'b0, prod};
            tmp_pkg::ST_AD:     ad_reg    <= {2'b0, prod};
            tmp_pkg::ST_HALF:   half_reg  <= (sq_vi_reg + sq_vf_reg) >> 1;
            tmp_pkg::ST_DIST_I: if (done_step) dist_i_reg <= quo_step;
            tmp_pkg::ST_DIST_F: if (done_step) dist_f_reg <= quo_step;
            tmp_pkg::ST_TRI_CHK:
            begin
                rad_reg <= ad_reg + half_reg;
                if (!tri_case)
                begin
                    peak_reg <= vc;
                end
            end
            tmp_pkg::ST_SQRT:
                if (done_step)
                begin
                    peak_reg <= (sr_step < {33'b0, vc}) ? sr_step[30:0] : vc;
                end
            tmp_pkg::ST_SQ_PK:  sq_pk_reg <= {2'b0, prod};
            tmp_pkg::ST_DA:     if (done_step) da_reg <= quo_step;
            tmp_pkg::ST_DD:     if (done_step) dd_reg <= quo_step;
            tmp_pkg::ST_TA:     if (done_step) ta_reg <= quo_step;
            tmp_pkg::ST_TD:     if (done_step) td_reg <= quo_step;
            tmp_pkg::ST_DADD:   dadd_reg <= da_reg + dd_reg;
            tmp_pkg::ST_DC:
                dc_reg <= (peak_reg != '0 && d64 > dadd_reg) ? d64 - dadd_reg : '0;
            tmp_pkg::ST_TC:
                if (done_step)
                begin
                    tc_reg <= (peak_reg == '0) ? '0 : quo_step;
                end
            tmp_pkg::ST_SUM1:
            begin
                dadc_reg <= da_reg + dc_reg;
                t1_reg   <= ta_reg + tc_reg;
                vend_reg <= (peak_reg > vf) ? vf : peak_reg;
            end
            tmp_pkg::ST_SUM2:
            begin
                dsum_reg <= dadc_reg + dd_reg;
                t2_reg   <= t1_reg + td_reg;
            end
            default: ;
        endcase
    end

    assign prof.busy = (state_reg != tmp_pkg::ST_DONE);
    assign prof.err  = err_reg;
    assign prof.peak = peak_reg;
    assign prof.vend = vend_reg;
    assign prof.da   = da_reg;
    assign prof.dadc = dadc_reg;
    assign prof.dsum = dsum_reg;
    assign prof.ta   = ta_reg;
    assign prof.t1   = t1_reg;
    assign prof.t2   = t2_reg;

endmodule

FILE: rtl/core/trapezoidal_motion_profile_core.sv
`timescale 1ns / 1ps
// The core takes one query per cycle while in_stall is low, through a six-stage
// pipeline (capture, phase select, two multiplier stages, combine, position add
// and saturate). After reset and after every register write the setup sequencer
// runs seven 64-step divisions and, for a triangular profile, a 32-step square
// root, unless the acceleration is zero; in_stall is high while it runs.
// Reset clears the configuration registers to zero and clears every pipeline valid bit.

module trapezoidal_motion_profile_core #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration write port.
    input  logic                         cfg_wr_en,
    input  logic [tmp_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [tmp_pkg::REG_BITS-1:0] cfg_data,
    // Query channel.
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [30:0]                  query_time,
    // Result channel.
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [31:0]           velocity_out,
    output logic signed [31:0]           accel_out,
    output logic signed [31:0]           position_out,
    output logic [1:0]                   phase,
    output logic                         error_flag
);

    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    // Saturate to a signed WORD_BITS value, then keep the low 32 bits.
    function automatic logic [31:0] sat_word(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO;
        end
        else
        begin
            r = v;
        end
        return r[31:0];
    endfunction

    // Configuration registers. Writes restart the setup sequencer.
    logic [tmp_pkg::REG_BITS-1:0] vi_reg, vc_reg, acc_reg, vf_reg, dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vi_reg   <= '0;
            vc_reg   <= '0;
            acc_reg  <= '0;
            vf_reg   <= '0;
            dist_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tmp_pkg::CFG_START_VEL:  vi_reg   <= cfg_data;
                tmp_pkg::CFG_CRUISE_VEL: vc_reg   <= cfg_data;
                tmp_pkg::CFG_ACCEL:      acc_reg  <= cfg_data;
                tmp_pkg::CFG_END_VEL:    vf_reg   <= cfg_data;
                tmp_pkg::CFG_DISTANCE:   dist_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tmp_pkg::prof_t prof;

    tmp_setup #(
        .FRAC_BITS (FRAC_BITS)
    ) u_setup (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_wr_en),
        .vi     (vi_reg),
        .vc     (vc_reg),
        .acc    (acc_reg),
        .vf     (vf_reg),
        .travel (dist_reg),
        .prof   (prof)
    );

    // Each stage moves on when it is empty or the stage after it moves on, so
    // bubbles fill up even while the output beat is held.
    logic va_reg, vb_reg, vc_s_reg, vd_reg, ve_reg, vf_s_reg;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;

    assign rdy_f    = !vf_s_reg || !out_stall;
    assign rdy_e    = !ve_reg   || rdy_f;
    assign rdy_d    = !vd_reg   || rdy_e;
    assign rdy_c    = !vc_s_reg || rdy_d;
    assign rdy_b    = !vb_reg   || rdy_c;
    assign rdy_a    = !va_reg   || rdy_b;
    assign in_stall = !rdy_a || prof.busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_s_reg <= 1'b0;
            vd_reg   <= 1'b0;
            ve_reg   <= 1'b0;
            vf_s_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a) va_reg   <= in_valid && !in_stall;
            if (rdy_b) vb_reg   <= va_reg;
            if (rdy_c) vc_s_reg <= vb_reg;
            if (rdy_d) vd_reg   <= vc_s_reg;
            if (rdy_e) ve_reg   <= vd_reg;
            if (rdy_f) vf_s_reg <= ve_reg;
        end
    end

    // Stage A: capture the query time.
    logic [30:0] t_a_reg;

    // Stage B: phase and the time offset from the start of that phase.
    tmp_pkg::phase_t ph_b_next, ph_b_reg, ph_c_reg, ph_d_reg, ph_e_reg;
    logic [30:0] x_b_next, x_b_reg, x_c_reg;
    logic [63:0] t64;

    assign t64 = {33'b0, t_a_reg};

    always_comb
    begin
        if (t64 < prof.ta)
        begin
            ph_b_next = tmp_pkg::PH_ACCEL;
            x_b_next  = t_a_reg;
        end
        else if (t64 < prof.t1)
        begin
            ph_b_next = tmp_pkg::PH_CRUISE;
            x_b_next  = t_a_reg - prof.ta[30:0];
        end
        else if (t64 < prof.t2)
        begin
            ph_b_next = tmp_pkg::PH_DECEL;
            x_b_next  = t_a_reg - prof.t1[30:0];
        end
        else
        begin
            ph_b_next = tmp_pkg::PH_DONE;
            x_b_next  = '0;
        end
    end

    // Stage C: a*x (velocity change) and base velocity times x.
    logic [30:0] base_v;
    logic [61:0] pax_c_reg, pvx_c_reg;

    assign base_v = (ph_b_reg == tmp_pkg::PH_ACCEL) ? vi_reg : prof.peak;

    // Stage D: gain g = a*x >> F, and g*x split into two narrow products.
    logic [63:0] g_next, g_d_reg, glo_d_reg, ghi_d_reg, pvx_d_reg;
    logic [63:0] glo_prod, ghi_prod;

    assign g_next   = {2'b0, pax_c_reg} >> FRAC_BITS;
    assign glo_prod = g_next[31:0] * x_c_reg;
    assign ghi_prod = g_next[63:32] * x_c_reg;

    // Stage E: half of g*x folded into the velocity-time product; velocity.
    logic [31:0] q_hi;
    logic [63:0] h_e, sum_next, sum_e_reg, vel_next, vel_e_reg;

    assign q_hi = glo_d_reg[63:32] + ghi_d_reg[31:0];
    assign h_e  = {q_hi, glo_d_reg[31:0]} >> 1;

    always_comb
    begin
        case (ph_d_reg)
            tmp_pkg::PH_ACCEL:
            begin
                sum_next = pvx_d_reg + h_e;
                vel_next = {33'b0, vi_reg} + g_d_reg;
            end
            tmp_pkg::PH_CRUISE:
            begin
                sum_next = pvx_d_reg;
                vel_next = {33'b0, prof.peak};
            end
            tmp_pkg::PH_DECEL:
            begin
                sum_next = pvx_d_reg - h_e;
                vel_next = {33'b0, prof.peak} - g_d_reg;
            end
            default:
            begin
                sum_next = '0;
                vel_next = {33'b0, prof.vend};
            end
        endcase
    end

    // Stage F: position offset by its phase start, acceleration, saturation.
    logic [63:0] pos_next;
    logic signed [63:0] acc_next;
    logic [31:0] vel_reg, accel_reg, pos_reg;
    tmp_pkg::phase_t phase_reg;
    logic err_reg;

    always_comb
    begin
        case (ph_e_reg)
            tmp_pkg::PH_ACCEL:
            begin
                pos_next = sum_e_reg >> FRAC_BITS;
                acc_next = signed'({33'b0, acc_reg});
            end
            tmp_pkg::PH_CRUISE:
            begin
                pos_next = prof.da + (sum_e_reg >> FRAC_BITS);
                acc_next = '0;
            end
            tmp_pkg::PH_DECEL:
            begin
                pos_next = prof.dadc + (sum_e_reg >> FRAC_BITS);
                acc_next = -signed'({33'b0, acc_reg});
            end
            default:
            begin
                pos_next = prof.dsum;
                acc_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            t_a_reg <= query_time;
        end
        if (rdy_b)
        begin
            ph_b_reg <= ph_b_next;
            x_b_reg  <= x_b_next;
        end
        if (rdy_c)
        begin
            ph_c_reg  <= ph_b_reg;
            x_c_reg   <= x_b_reg;
            pax_c_reg <= acc_reg * x_b_reg;
            pvx_c_reg <= base_v * x_b_reg;
        end
        if (rdy_d)
        begin
            ph_d_reg  <= ph_c_reg;
            g_d_reg   <= g_next;
            glo_d_reg <= glo_prod;
            ghi_d_reg <= ghi_prod;
            pvx_d_reg <= {2'b0, pvx_c_reg};
        end
        if (rdy_e)
        begin
            ph_e_reg  <= ph_d_reg;
            sum_e_reg <= sum_next;
            vel_e_reg <= vel_next;
        end
        if (rdy_f)
        begin
            if (prof.err)
            begin
                vel_reg   <= '0;
                accel_reg <= '0;
                pos_reg   <= '0;
                phase_reg <= tmp_pkg::PH_DONE;
                err_reg   <= 1'b1;
            end
            else
            begin
                vel_reg   <= sat_word(signed'(vel_e_reg));
                accel_reg <= sat_word(acc_next);
                pos_reg   <= sat_word(signed'(pos_next));
                phase_reg <= ph_e_reg;
                err_reg   <= 1'b0;
            end
        end
    end

    assign out_valid    = vf_s_reg;
    assign velocity_out = signed'(vel_reg);
    assign accel_out    = signed'(accel_reg);
    assign position_out = signed'(pos_reg);
    assign phase        = phase_reg;
    assign error_flag   = err_reg;

endmodule
